@@ rtl/rs485fc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rs485fc_pkg
// Shared types, constants and the byte-wide CRC-16 step of the RS485 response
// frame checker.
// ----------------------------------------------------------------------------
package rs485fc_pkg;

    localparam int BUFFER_BYTES   = 16;
    localparam int CNT_W          = $clog2(BUFFER_BYTES + 1);
    localparam int FRAME_OVERHEAD = 9;
    localparam int DATA_START     = 6;
    localparam int IN_TDATA_W     = 32;
    localparam int OUT_TDATA_W    = 40;

    localparam logic [7:0]  FRAME_STX      = 8'h02;
    localparam logic [7:0]  FRAME_ETX      = 8'h03;
    localparam logic [15:0] CRC_POLY       = 16'hA001;
    localparam logic [7:0]  GATEWAY_RESET  = 8'h06;
    localparam logic [7:0]  DEVICE_RESET   = 8'h01;
    localparam logic [2:0]  DATA_LEN_RESET = 3'd2;

    typedef enum logic [1:0] {
        FUNC_BYTE   = 2'd0,
        FUNC_ARM    = 2'd1,
        FUNC_DISARM = 2'd2
    } func_t;

    typedef enum logic {
        CFG_GATEWAY = 1'b0,
        CFG_DEVICE  = 1'b1
    } cfg_index_t;

    typedef enum logic {
        ST_DISARMED = 1'b0,
        ST_ARMED    = 1'b1
    } state_t;

    typedef struct packed {
        logic load_expect;
        logic store_byte;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic buf_full;
        logic frame_last;
        logic rx_zero;
    } dp_status_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

@@ rtl/rs485fc_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rs485fc_ctrl
// Arm state machine and output handshake: decodes each accepted word and
// issues load, store and emit commands to the datapath.
// ----------------------------------------------------------------------------
module rs485fc_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_fire,
    input  wire logic [1:0]             in_func,
    input  wire logic                   m_tready,
    input  wire rs485fc_pkg::dp_status_t status,
    output rs485fc_pkg::dp_cmd_t        cmd,
    output logic                        s_tready,
    output logic                        m_tvalid
);

    rs485fc_pkg::state_t state_reg, state_next;
    logic                out_valid_reg, out_valid_next;
    logic                store_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rs485fc_pkg::ST_DISARMED;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        store_ok        = !(status.rx_zero && status.count_zero) && !status.buf_full;
        if (in_fire)
        begin
            case (rs485fc_pkg::func_t'(in_func))
                rs485fc_pkg::FUNC_ARM:
                begin
                    cmd.load_expect = 1'b1;
                    state_next      = rs485fc_pkg::ST_ARMED;
                end
                rs485fc_pkg::FUNC_DISARM:
                begin
                    state_next = rs485fc_pkg::ST_DISARMED;
                end
                rs485fc_pkg::FUNC_BYTE:
                begin
                    if (state_reg == rs485fc_pkg::ST_ARMED && store_ok)
                    begin
                        cmd.store_byte = 1'b1;
                        cmd.emit       = status.frame_last;
                    end
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
        end
        out_valid_next = cmd.emit || (out_valid_reg && !m_tready);
    end

    assign s_tready = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;

endmodule
`default_nettype wire

@@ rtl/rs485fc_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rs485fc_dp
// Frame datapath: byte counter, expectation and config registers, running
// CRC, captured header fields, data value and the result word register.
// ----------------------------------------------------------------------------
module rs485fc_dp (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic [rs485fc_pkg::IN_TDATA_W-1:0]    in_data,
    input  wire logic                                  cfg_write,
    input  wire logic                                  cfg_index,
    input  wire logic [7:0]                            cfg_data,
    input  wire rs485fc_pkg::dp_cmd_t                  cmd,
    output rs485fc_pkg::dp_status_t                    status,
    output logic [rs485fc_pkg::OUT_TDATA_W-1:0]        out_data
);

    localparam int CW = rs485fc_pkg::CNT_W;

    logic [7:0]    rx;
    logic [7:0]    in_group;
    logic [7:0]    in_item;
    logic [2:0]    in_len;

    logic [CW-1:0] count_reg, count_next;
    logic [2:0]    exp_len_reg;
    logic [7:0]    exp_group_reg, exp_item_reg;
    logic [7:0]    gateway_reg, device_reg;

    logic [15:0]   crc_reg, crc_next;
    logic [3:0]    hdr_ok_reg, hdr_ok_next;
    logic [7:0]    addr_reg, addr_next;
    logic [7:0]    id_reg, id_next;
    logic [7:0]    crc_lo_reg, crc_lo_next;
    logic [7:0]    crc_hi_reg, crc_hi_next;
    logic [31:0]   value_reg, value_next;

    logic          res_hdr_reg, res_crc_reg, res_vv_reg;
    logic [31:0]   res_value_reg;

    logic [CW-1:0] n_ext, crc_end, last_pos;
    logic          hdr_ok, crc_ok, len_ok, vv;

    assign rx       = in_data[7:0];
    assign in_group = in_data[15:8];
    assign in_item  = in_data[23:16];
    assign in_len   = in_data[26:24];

    assign n_ext    = {{(CW-3){1'b0}}, exp_len_reg};
    assign crc_end  = n_ext + CW'(rs485fc_pkg::DATA_START);
    assign last_pos = n_ext + CW'(rs485fc_pkg::FRAME_OVERHEAD - 1);

    assign status.count_zero = (count_reg == '0);
    assign status.buf_full   = (count_reg == CW'(rs485fc_pkg::BUFFER_BYTES));
    assign status.frame_last = (count_reg == last_pos);
    assign status.rx_zero    = (rx == 8'h00);

    // per-position capture of the incoming byte
    always_comb
    begin
        count_next  = count_reg;
        crc_next    = crc_reg;
        hdr_ok_next = hdr_ok_reg;
        addr_next   = addr_reg;
        id_next     = id_reg;
        crc_lo_next = crc_lo_reg;
        crc_hi_next = crc_hi_reg;
        value_next  = value_reg;
        if (cmd.load_expect)
        begin
            count_next = '0;
        end
        else if (cmd.store_byte)
        begin
            count_next = cmd.emit ? '0 : count_reg + CW'(1);
            if (count_reg == '0)
            begin
                hdr_ok_next[0] = (rx == rs485fc_pkg::FRAME_STX);
                crc_next       = '0;
                value_next     = '0;
            end
            if (count_reg == CW'(1))
            begin
                addr_next = rx;
            end
            if (count_reg == CW'(2))
            begin
                id_next = rx;
            end
            if (count_reg == CW'(3))
            begin
                hdr_ok_next[1] = (rx == ({5'b0, exp_len_reg} + 8'd2));
            end
            if (count_reg == CW'(4))
            begin
                hdr_ok_next[2] = (rx == exp_group_reg);
            end
            if (count_reg == CW'(5))
            begin
                hdr_ok_next[3] = (rx == exp_item_reg);
            end
            if (count_reg != '0 && count_reg < crc_end)
            begin
                crc_next = rs485fc_pkg::crc16_byte(crc_reg, rx);
            end
            if (count_reg >= CW'(rs485fc_pkg::DATA_START) && count_reg < crc_end)
            begin
                value_next = {value_reg[23:0], rx};
            end
            if (count_reg == crc_end)
            begin
                crc_lo_next = rx;
            end
            if (count_reg == crc_end + CW'(1))
            begin
                crc_hi_next = rx;
            end
        end
    end

    // closing byte is the etx, checked as it arrives
    assign len_ok = (exp_len_reg == 3'd1) || (exp_len_reg == 3'd2) || (exp_len_reg == 3'd4);
    assign hdr_ok = (&hdr_ok_reg) && (addr_reg == gateway_reg) && (id_reg == device_reg)
                    && (rx == rs485fc_pkg::FRAME_ETX);
    assign crc_ok = ({crc_hi_reg, crc_lo_reg} == crc_reg);
    assign vv     = crc_ok && len_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            exp_len_reg   <= rs485fc_pkg::DATA_LEN_RESET;
            exp_group_reg <= '0;
            exp_item_reg  <= '0;
            gateway_reg   <= rs485fc_pkg::GATEWAY_RESET;
            device_reg    <= rs485fc_pkg::DEVICE_RESET;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.load_expect)
            begin
                exp_len_reg   <= in_len;
                exp_group_reg <= in_group;
                exp_item_reg  <= in_item;
            end
            if (cfg_write && cfg_index == rs485fc_pkg::CFG_GATEWAY)
            begin
                gateway_reg <= cfg_data;
            end
            if (cfg_write && cfg_index == rs485fc_pkg::CFG_DEVICE)
            begin
                device_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        crc_reg    <= crc_next;
        hdr_ok_reg <= hdr_ok_next;
        addr_reg   <= addr_next;
        id_reg     <= id_next;
        crc_lo_reg <= crc_lo_next;
        crc_hi_reg <= crc_hi_next;
        value_reg  <= value_next;
        if (cmd.emit)
        begin
            res_hdr_reg   <= hdr_ok;
            res_crc_reg   <= crc_ok;
            res_vv_reg    <= vv;
            res_value_reg <= vv ? value_reg : 32'h0;
        end
    end

    assign out_data = {5'b0, res_value_reg, res_vv_reg, res_crc_reg, res_hdr_reg};

endmodule
`default_nettype wire

@@ rtl/rs485_response_frame_checker_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rs485_response_frame_checker_unit
// Collects and checks reply frames of a polled RS485 instrument.
// ----------------------------------------------------------------------------
// Each accepted word is handled at once: the CRC-16 is folded in one byte per
// accepted word by a byte-wide CRC step, so the frame needs no buffer walk at
// its end. The result word is registered and shows on m_tvalid in the cycle
// after the closing ETX byte is accepted; s_tready is low only while a result
// is waiting and m_tready is low. gateway_address is config index 0 and
// device_id index 1.
module rs485_response_frame_checker_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // rx_byte[7:0], cmd_group[15:8], cmd_item[23:16], resp_data_len[26:24]
    input  wire logic [31:0] s_tdata,
    // func[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // header_ok[0], crc_ok[1], value_valid[2], value[34:3]
    output logic [39:0]      m_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_data
);

    rs485fc_pkg::dp_cmd_t    cmd;
    rs485fc_pkg::dp_status_t status;
    logic                    in_fire;

    assign cfg_ready = 1'b1;
    assign in_fire   = s_tvalid && s_tready;

    rs485fc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .in_func  (s_tuser),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid)
    );

    rs485fc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_tdata),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_data  (m_tdata)
    );

    // a new result only follows an accepted word
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
        else $error("result without accepted word");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[2] |-> m_tdata[34:3] == 32'h0)
        else $error("value not zero while invalid");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2] |-> m_tdata[1])
        else $error("value valid without good crc");

    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without pending result");

endmodule
`default_nettype wire

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the RS485 response frame checker unit.
// ----------------------------------------------------------------------------
// A queue of serial words (arm, timeout, received byte, unused code) feeds a
// bursty stream driver. Most of the stimulus is whole reply frames with
// correct or damaged header, data and CRC bytes, and the rest is noise. The
// monitor keeps its own copy of the frame state and registers, predicts each
// checked frame, and compares every result word field by field. The run goes
// through five address/id settings, written only while the unit is idle.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [1:0] FUNC_UNUSED   = 2'd3;
    localparam int         FAULT_NONE    = 0;
    localparam int         FAULT_BYTE    = 1;
    localparam int         FAULT_HEADER  = 2;
    localparam int         FAULT_CRC     = 3;
    localparam int         PHASE_COUNT   = 5;
    localparam int         PHASE_WORDS   = 290;
    localparam int         CYCLE_LIMIT   = 400000;
    localparam int         REPORT_LIMIT  = 10;

    typedef bit [7:0] frame_t [rs485fc_pkg::BUFFER_BYTES];

    typedef struct packed {
        logic [1:0] func;
        logic [2:0] len;
        logic [7:0] item;
        logic [7:0] group;
        logic [7:0] rx;
    } serial_word_t;

    // header_ok in the lowest bit, as on m_tdata
    typedef struct packed {
        logic [31:0] value;
        logic        value_valid;
        logic        crc_ok;
        logic        header_ok;
    } reply_check_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [7:0]  cfg_data  = '0;

    serial_word_t serial_words [$];
    reply_check_t due_replies [$];

    // stream driver pacing
    bit          s_fired    = 1'b0;
    int          gap_left   = 0;
    int          burst_left = 1;
    int          gap_max    = 0;
    bit [15:0]   stall_mask = '0;
    bit [3:0]    stall_pos  = '0;

    // stimulus copy of the registers
    bit [7:0]    stim_gw    = rs485fc_pkg::GATEWAY_RESET;
    bit [7:0]    stim_dev   = rs485fc_pkg::DEVICE_RESET;

    // predictor state
    frame_t      frame_buf  = '{default: 8'h00};
    int          fill_count = 0;
    bit          is_armed   = 1'b0;
    bit [7:0]    want_group = '0;
    bit [7:0]    want_item  = '0;
    bit [2:0]    want_len   = rs485fc_pkg::DATA_LEN_RESET;
    bit [7:0]    pred_gw    = rs485fc_pkg::GATEWAY_RESET;
    bit [7:0]    pred_dev   = rs485fc_pkg::DEVICE_RESET;

    int          words_made     = 0;
    int          frames_checked = 0;
    int          values_seen    = 0;
    int          header_faults  = 0;
    int          crc_faults     = 0;
    int          mismatch_count = 0;
    int unsigned cycle_count    = 0;

    rs485_response_frame_checker_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic bit [7:0] rand_byte();
        return 8'($urandom);
    endfunction

    function automatic bit [2:0] rand_len();
        return 3'($urandom);
    endfunction

    // reflected crc-16 arc over bytes first .. stop-1
    function automatic bit [15:0] crc_arc(input frame_t b, input int first, input int stop);
        bit [15:0] crc;
        crc = '0;
        for (int i = first; i < stop; i++)
        begin
            crc = crc ^ {8'h00, b[i]};
            for (int k = 0; k < 8; k++)
                crc = (crc >> 1) ^ (crc[0] ? rs485fc_pkg::CRC_POLY : 16'h0000);
        end
        return crc;
    endfunction

    function automatic reply_check_t judge_frame();
        reply_check_t chk;
        int n;
        n = int'(want_len);
        chk = '0;
        chk.header_ok = frame_buf[0] == rs485fc_pkg::FRAME_STX && frame_buf[1] == pred_gw &&
                        frame_buf[2] == pred_dev && frame_buf[3] == 8'(n + 2) &&
                        frame_buf[4] == want_group && frame_buf[5] == want_item &&
                        frame_buf[n + 8] == rs485fc_pkg::FRAME_ETX;
        chk.crc_ok = crc_arc(frame_buf, 1, n + 6) == {frame_buf[n + 7], frame_buf[n + 6]};
        chk.value_valid = chk.crc_ok && (n == 1 || n == 2 || n == 4);
        if (chk.value_valid)
        begin
            case (n)
                1: chk.value = {24'h0, frame_buf[6]};
                2: chk.value = {16'h0, frame_buf[6], frame_buf[7]};
                default: chk.value = {frame_buf[6], frame_buf[7], frame_buf[8], frame_buf[9]};
            endcase
        end
        return chk;
    endfunction

    task automatic advance_frame_state(input logic [1:0] func, input logic [31:0] word);
        serial_word_t w;
        w = {func, word[26:0]};
        case (w.func)
            rs485fc_pkg::FUNC_ARM:
            begin
                want_group = w.group;
                want_item  = w.item;
                want_len   = w.len;
                is_armed   = 1'b1;
                fill_count = 0;
            end
            rs485fc_pkg::FUNC_DISARM:
                is_armed = 1'b0;
            rs485fc_pkg::FUNC_BYTE:
            begin
                if (is_armed)
                begin
                    if (w.rx == 8'h00 && fill_count == 0)
                        ;
                    else if (fill_count < rs485fc_pkg::BUFFER_BYTES)
                    begin
                        frame_buf[fill_count] = w.rx;
                        fill_count++;
                    end
                    if (fill_count >= int'(want_len) + rs485fc_pkg::FRAME_OVERHEAD)
                    begin
                        due_replies.push_back(judge_frame());
                        fill_count = 0;
                    end
                end
            end
            default:
                ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input reply_check_t want,
                                   input reply_check_t got);
        mismatch_count++;
        // fields in the order hdr crc valid value
        if (mismatch_count <= REPORT_LIMIT)
            $display("%s at cycle %0d: expected %0b %0b %0b %h, got %0b %0b %0b %h",
                     what, cycle_count, want.header_ok, want.crc_ok, want.value_valid,
                     want.value, got.header_ok, got.crc_ok, got.value_valid, got.value);
    endtask

    // result monitor and predictor
    always @(posedge clk)
    begin
        reply_check_t got;
        reply_check_t want;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("testbench failed");
            $finish;
        end
        else if (rst_n)
        begin
            s_fired = s_tvalid && s_tready;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == rs485fc_pkg::CFG_GATEWAY)
                    pred_gw = cfg_data;
                else
                    pred_dev = cfg_data;
            end
            if (s_fired)
                advance_frame_state(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[34:0];
                if (due_replies.size() == 0)
                    report_mismatch("no result expected", '0, got);
                else
                begin
                    want = due_replies.pop_front();
                    frames_checked++;
                    values_seen   += int'(want.value_valid);
                    header_faults += int'(!want.header_ok);
                    crc_faults    += int'(!want.crc_ok);
                    if (got.header_ok !== want.header_ok || got.crc_ok !== want.crc_ok ||
                        got.value_valid !== want.value_valid || got.value !== want.value)
                        report_mismatch("wrong field", want, got);
                end
            end
        end
    end

    // stream driver and receiver stall pattern
    always @(negedge clk)
    begin
        serial_word_t w;
        logic next_valid;
        if (rst_n)
        begin
            if (s_fired || !s_tvalid)
            begin
                next_valid = 1'b0;
                if (gap_left != 0)
                    gap_left--;
                else if (serial_words.size() != 0)
                begin
                    w = serial_words.pop_front();
                    next_valid = 1'b1;
                    s_tuser <= w.func;
                    s_tdata <= {5'b0, w.len, w.item, w.group, w.rx};
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
                    end
                    else
                        burst_left--;
                end
                s_tvalid <= next_valid;
            end
            m_tready  <= ~stall_mask[stall_pos];
            stall_pos <= stall_pos + 4'd1;
        end
    end

    task automatic push_word(input logic [1:0] func, input bit [7:0] rx, input bit [7:0] grp,
                             input bit [7:0] itm, input bit [2:0] len);
        serial_words.push_back({func, len, itm, grp, rx});
        if (func != FUNC_UNUSED)
            words_made++;
    endtask

    function automatic int pick_fault();
        case ($urandom_range(0, 9))
            7: return FAULT_BYTE;
            8: return FAULT_HEADER;
            9: return FAULT_CRC;
            default: return FAULT_NONE;
        endcase
    endfunction

    function automatic bit [2:0] pick_len();
        case ($urandom_range(0, 19))
            0, 1, 2: return 3'($urandom_range(0, 7));
            3, 4, 5, 6, 7, 8: return 3'd1;
            9, 10, 11, 12, 13: return 3'd2;
            default: return 3'd4;
        endcase
    endfunction

    // one reply frame, data from fill or random when fill is negative
    task automatic queue_reply(input bit [2:0] len, input bit [7:0] grp, input bit [7:0] itm,
                               input int fault, input int fill);
        frame_t f;
        int n;
        int pos;
        bit [15:0] crc;
        n = int'(len);
        f = '{default: 8'h00};
        f[0] = rs485fc_pkg::FRAME_STX;
        f[1] = stim_gw;
        f[2] = stim_dev;
        f[3] = 8'(n + 2);
        f[4] = grp;
        f[5] = itm;
        for (pos = rs485fc_pkg::DATA_START; pos < rs485fc_pkg::DATA_START + n; pos++)
            f[pos] = (fill < 0) ? 8'($urandom) : 8'(fill);
        crc = crc_arc(f, 1, n + 6);
        f[n + 6] = crc[7:0];
        f[n + 7] = crc[15:8];
        f[n + 8] = rs485fc_pkg::FRAME_ETX;
        case (fault)
            FAULT_BYTE:
                f[$urandom_range(0, n + 8)] ^= 8'($urandom_range(1, 255));
            FAULT_HEADER:
            begin
                pos = $urandom_range(0, 6);
                if (pos == 6)
                    pos = n + 8;
                f[pos] ^= 8'($urandom_range(1, 255));
            end
            FAULT_CRC:
                f[n + 6 + $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
            default:
                ;
        endcase
        for (pos = 0; pos < n + rs485fc_pkg::FRAME_OVERHEAD; pos++)
            push_word(rs485fc_pkg::FUNC_BYTE, f[pos], rand_byte(), rand_byte(), rand_len());
    endtask

    task automatic queue_sequence();
        int r;
        bit [2:0] len;
        bit [7:0] grp;
        bit [7:0] itm;
        r   = $urandom_range(0, 99);
        len = pick_len();
        grp = rand_byte();
        itm = rand_byte();
        if (r < 72)
        begin
            push_word(rs485fc_pkg::FUNC_ARM, rand_byte(), grp, itm, len);
            repeat ($urandom_range(0, 2))
                push_word(rs485fc_pkg::FUNC_BYTE, 8'h00, rand_byte(), rand_byte(), rand_len());
            queue_reply(len, grp, itm, pick_fault(), -1);
            if ($urandom_range(0, 2) == 0)
                queue_reply(len, grp, itm, pick_fault(), -1);
        end
        else if (r < 82)
        begin
            // frame cut short by a timeout, later bytes ignored
            push_word(rs485fc_pkg::FUNC_ARM, rand_byte(), grp, itm, len);
            repeat ($urandom_range(1, len + 8))
                push_word(rs485fc_pkg::FUNC_BYTE, 8'($urandom_range(1, 255)), rand_byte(),
                          rand_byte(), rand_len());
            push_word(rs485fc_pkg::FUNC_DISARM, rand_byte(), rand_byte(), rand_byte(),
                      rand_len());
            repeat ($urandom_range(1, 3))
                push_word(rs485fc_pkg::FUNC_BYTE, rand_byte(), rand_byte(), rand_byte(),
                          rand_len());
        end
        else
        begin
            repeat ($urandom_range(1, 6))
            begin
                case ($urandom_range(0, 9))
                    0: push_word(rs485fc_pkg::FUNC_ARM, rand_byte(), rand_byte(), rand_byte(),
                                 rand_len());
                    1: push_word(rs485fc_pkg::FUNC_DISARM, rand_byte(), rand_byte(),
                                 rand_byte(), rand_len());
                    2: push_word(FUNC_UNUSED, rand_byte(), rand_byte(), rand_byte(),
                                 rand_len());
                    default: push_word(rs485fc_pkg::FUNC_BYTE, rand_byte(), rand_byte(),
                                       rand_byte(), rand_len());
                endcase
            end
        end
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (serial_words.size() != 0 || s_tvalid || due_replies.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_register(input rs485fc_pkg::cfg_index_t idx, input bit [7:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (idx == rs485fc_pkg::CFG_GATEWAY)
            stim_gw = val;
        else
            stim_dev = val;
    endtask

    initial
    begin
        bit [7:0] gw;
        bit [7:0] dev;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed opening
        push_word(FUNC_UNUSED, 8'hFF, 8'hFF, 8'hFF, 3'h7);
        push_word(rs485fc_pkg::FUNC_BYTE, rs485fc_pkg::FRAME_STX, 8'h00, 8'h00, 3'h0);
        push_word(rs485fc_pkg::FUNC_ARM, 8'h00, 8'hFF, 8'h00, 3'd4);
        push_word(rs485fc_pkg::FUNC_BYTE, 8'h00, 8'h00, 8'h00, 3'h0);
        queue_reply(3'd4, 8'hFF, 8'h00, FAULT_NONE, 8'hFF);
        push_word(rs485fc_pkg::FUNC_DISARM, 8'h00, 8'h00, 8'h00, 3'h0);
        push_word(rs485fc_pkg::FUNC_BYTE, 8'hFF, 8'hFF, 8'hFF, 3'h7);

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                1:
                begin
                    gw         = 8'h00;
                    dev        = 8'hFF;
                    gap_max    = 6;
                    stall_mask = 16'($urandom & $urandom);
                end
                2:
                begin
                    gw         = 8'hFF;
                    dev        = 8'h00;
                    gap_max    = 0;
                    stall_mask = 16'($urandom | $urandom);
                end
                3:
                begin
                    gw         = rand_byte();
                    dev        = rand_byte();
                    gap_max    = 10;
                    stall_mask = '0;
                end
                4:
                begin
                    gw         = 8'h5A;
                    dev        = 8'hA5;
                    gap_max    = 3;
                    stall_mask = 16'($urandom);
                end
                default:
                begin
                    gw         = stim_gw;
                    dev        = stim_dev;
                    gap_max    = 0;
                    stall_mask = '0;
                end
            endcase
            stall_mask[0] = 1'b0;
            if (p != 0)
            begin
                // sender holds off until every result of the last phase is in
                wait_idle();
                if ($urandom_range(0, 1) == 0)
                begin
                    write_register(rs485fc_pkg::CFG_GATEWAY, gw);
                    write_register(rs485fc_pkg::CFG_DEVICE, dev);
                end
                else
                begin
                    write_register(rs485fc_pkg::CFG_DEVICE, dev);
                    write_register(rs485fc_pkg::CFG_GATEWAY, gw);
                end
            end
            while (words_made < (p + 1) * PHASE_WORDS)
                queue_sequence();
        end

        wait_idle();
        $display("covered %0d input words over %0d address/id settings", words_made, PHASE_COUNT);
        $display("checked %0d frames: %0d values, %0d header faults, %0d crc faults",
                 frames_checked, values_seen, header_faults, crc_faults);
        if (mismatch_count == 0)
            $display("testbench passed");
        else
        begin
            $display("%0d mismatches", mismatch_count);
            $display("testbench failed");
        end
        $finish;
    end

endmodule
